[design/tplf_pkg.sv]
// Shared widths, constants and register codes for the three-point local frame.
`timescale 1ns / 1ps
package tplf_pkg;

  localparam int COORD_W = 32;
  localparam int DIFF_W  = 33;
  localparam int MAG_W   = 30;
  localparam int PRE_W   = 31;
  localparam int OUT_W   = 32;
  localparam int PROD_W  = 63;
  localparam int LIMIT_W = 31;
  localparam int ADDR_W  = 3;
  localparam int DATA_W  = 32;

  localparam int PRE_TOP = 29;

  localparam logic signed [OUT_W-1:0] ONE_Q30 = 32'sh4000_0000;
  localparam logic [LIMIT_W-1:0] LIMIT_RST = 31'd1072668082;

  localparam logic REG_USE_DEFAULT = 1'b0;
  localparam logic REG_LIMIT       = 1'b1;

endpackage

[design/tplf_point_if.sv]
// Request channel carrying the three input points.
`timescale 1ns / 1ps
interface tplf_point_if;
  logic valid;
  logic ready;
  logic signed [31:0] origin_x;
  logic signed [31:0] origin_y;
  logic signed [31:0] origin_z;
  logic signed [31:0] axis_pt_x;
  logic signed [31:0] axis_pt_y;
  logic signed [31:0] axis_pt_z;
  logic signed [31:0] plane_pt_x;
  logic signed [31:0] plane_pt_y;
  logic signed [31:0] plane_pt_z;

  modport source (
    output valid, origin_x, origin_y, origin_z, axis_pt_x, axis_pt_y, axis_pt_z,
    output plane_pt_x, plane_pt_y, plane_pt_z,
    input ready
  );
  modport sink (
    input valid, origin_x, origin_y, origin_z, axis_pt_x, axis_pt_y, axis_pt_z,
    input plane_pt_x, plane_pt_y, plane_pt_z,
    output ready
  );
endinterface

[design/tplf_frame_if.sv]
// Result channel carrying the rotation matrix and the degenerate flag.
`timescale 1ns / 1ps
interface tplf_frame_if;
  logic valid;
  logic ready;
  logic signed [31:0] m00;
  logic signed [31:0] m01;
  logic signed [31:0] m02;
  logic signed [31:0] m10;
  logic signed [31:0] m11;
  logic signed [31:0] m12;
  logic signed [31:0] m20;
  logic signed [31:0] m21;
  logic signed [31:0] m22;
  logic degenerate;

  modport source (
    output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, degenerate,
    input ready
  );
  modport sink (
    input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, degenerate,
    output ready
  );
endinterface

[design/tplf_prescale.sv]
// Three-stage prescaler that brings the largest component of a vector into [2^29, 2^30).
`timescale 1ns / 1ps
module tplf_prescale #(
  parameter int W  = 33,
  parameter int SW = 1
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  en,
  input  logic                                  v_in,
  input  logic signed [W-1:0]                   vec_in [3],
  input  logic [SW-1:0]                         side_in,
  output logic                                  v_out,
  output logic signed [tplf_pkg::PRE_W-1:0]     vec_out [3],
  output logic [SW-1:0]                         side_out
);

  localparam int PW = $clog2(W);

  logic          v0, v1, v2;
  logic [W-1:0]  mag0 [3];
  logic [W-1:0]  mag1 [3];
  logic [2:0]    sgn0, sgn1;
  logic [W-1:0]  orv0;
  logic [PW-1:0] pos1;
  logic [SW-1:0] side0, side1, side2;

  logic [W-1:0]  mag_c [3];
  logic [W-1:0]  orv_c;
  logic [PW-1:0] pos_c;
  logic [W-1:0]  shv_c [3];

  always_comb begin
    orv_c = '0;
    for (int c = 0; c < 3; c++) begin
      mag_c[c] = vec_in[c][W-1] ? W'(-vec_in[c]) : W'(vec_in[c]);
      orv_c    = orv_c | mag_c[c];
    end
  end

  always_comb begin
    pos_c = '0;
    for (int i = 0; i < W; i++) begin
      if (orv0[i]) pos_c = PW'(i);
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (pos1 >= PW'(tplf_pkg::PRE_TOP)) begin
        shv_c[c] = mag1[c] >> (pos1 - PW'(tplf_pkg::PRE_TOP));
      end else begin
        shv_c[c] = mag1[c] << (PW'(tplf_pkg::PRE_TOP) - pos1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (en) begin
      v0 <= v_in;
      v1 <= v0;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      orv0  <= orv_c;
      side0 <= side_in;
      pos1  <= pos_c;
      sgn1  <= sgn0;
      side1 <= side0;
      side2 <= side1;
      for (int c = 0; c < 3; c++) begin
        mag0[c] <= mag_c[c];
        sgn0[c] <= vec_in[c][W-1];
        mag1[c] <= mag0[c];
        vec_out[c] <= sgn1[c] ? -{1'b0, shv_c[c][tplf_pkg::MAG_W-1:0]}
                              : {1'b0, shv_c[c][tplf_pkg::MAG_W-1:0]};
      end
    end
  end

  assign v_out    = v2;
  assign side_out = side2;

endmodule

[design/tplf_norm.sv]
// Pipelined normalizer: sum of squares, bit-per-stage square root and bit-per-stage divide.
`timescale 1ns / 1ps
module tplf_norm #(
  parameter int SW = 1
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  en,
  input  logic                                  v_in,
  input  logic signed [tplf_pkg::PRE_W-1:0]     vec_in [3],
  input  logic [SW-1:0]                         side_in,
  output logic                                  v_out,
  output logic signed [tplf_pkg::OUT_W-1:0]     vec_out [3],
  output logic [SW-1:0]                         side_out
);

  localparam int MW      = tplf_pkg::MAG_W;
  localparam int NSTEP   = MW + 1;
  localparam int ST_PREP = NSTEP + 2;
  localparam int NST     = 2 * NSTEP + 4;
  localparam int SQ_W    = 2 * MW;
  localparam int SUM_W   = SQ_W + 2;
  localparam int ISQ_W   = SUM_W + 1;
  localparam int ROOT_W  = NSTEP;
  localparam int NUM_W   = SQ_W + 1;

  logic              v    [NST];
  logic [SW-1:0]     side [NST];
  logic [2:0]        sgn  [NST-1];
  logic [MW-1:0]     mag  [ST_PREP][3];
  logic [SQ_W-1:0]   sq   [3];
  logic [SUM_W-1:0]  sum_s;
  logic [ISQ_W-1:0]  isq_s [NSTEP];
  logic [ISQ_W-1:0]  isq_r [NSTEP];
  logic [ROOT_W-1:0] root_p;
  logic [NUM_W-1:0]  num_p [3];
  logic [NUM_W-1:0]  div_rem [NSTEP][3];
  logic [ROOT_W-1:0] div_q   [NSTEP][3];
  logic [ROOT_W-1:0] div_r   [NSTEP];

  logic signed [tplf_pkg::PRE_W-1:0] neg_in [3];
  logic [MW-1:0]     mag_in [3];
  logic [ROOT_W-1:0] root_c;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      neg_in[c] = -vec_in[c];
      mag_in[c] = vec_in[c][tplf_pkg::PRE_W-1] ? neg_in[c][MW-1:0] : vec_in[c][MW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NST; i++) v[i] <= 1'b0;
    end else if (en) begin
      v[0] <= v_in;
      for (int i = 1; i < NST; i++) v[i] <= v[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side[0] <= side_in;
      for (int i = 1; i < NST; i++) side[i] <= side[i-1];
      for (int c = 0; c < 3; c++) begin
        sgn[0][c] <= vec_in[c][tplf_pkg::PRE_W-1];
        mag[0][c] <= mag_in[c];
        sq[c]     <= mag_in[c] * mag_in[c];
      end
      for (int i = 1; i < NST - 1; i++) sgn[i] <= sgn[i-1];
      for (int i = 1; i < ST_PREP; i++) begin
        for (int c = 0; c < 3; c++) mag[i][c] <= mag[i-1][c];
      end
      sum_s <= SUM_W'(sq[0]) + SUM_W'(sq[1]) + SUM_W'(sq[2]);
    end
  end

  for (genvar j = 0; j < NSTEP; j++) begin : g_isq
    localparam int K = NSTEP - 1 - j;
    localparam logic [ISQ_W-1:0] BITV = ISQ_W'(1) << (2 * K);
    logic [ISQ_W-1:0] s_prev, r_prev, t;
    if (j == 0) begin : g_first
      assign s_prev = ISQ_W'(sum_s);
      assign r_prev = '0;
    end else begin : g_rest
      assign s_prev = isq_s[j-1];
      assign r_prev = isq_r[j-1];
    end
    assign t = r_prev + BITV;
    always_ff @(posedge clk) begin
      if (en) begin
        if (s_prev >= t) begin
          isq_s[j] <= s_prev - t;
          isq_r[j] <= (r_prev >> 1) + BITV;
        end else begin
          isq_s[j] <= s_prev;
          isq_r[j] <= r_prev >> 1;
        end
      end
    end
  end

  // A zero vector gives a zero root; a divisor of one keeps the quotient at zero.
  assign root_c = (isq_r[NSTEP-1][ROOT_W-1:0] == '0) ? ROOT_W'(1)
                                                      : isq_r[NSTEP-1][ROOT_W-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      root_p <= root_c;
      for (int c = 0; c < 3; c++) begin
        num_p[c] <= NUM_W'({mag[ST_PREP-1][c], {MW{1'b0}}}) + NUM_W'(root_c >> 1);
      end
    end
  end

  for (genvar j = 0; j < NSTEP; j++) begin : g_div
    localparam int K = NSTEP - 1 - j;
    logic [NUM_W-1:0]  rem_prev [3];
    logic [ROOT_W-1:0] q_prev   [3];
    logic [ROOT_W-1:0] r_prev;
    logic [NUM_W:0]    dv;
    logic [NUM_W:0]    rx [3];
    logic [NUM_W:0]    rd [3];
    if (j == 0) begin : g_first
      assign r_prev = root_p;
      for (genvar c = 0; c < 3; c++) begin : g_c
        assign rem_prev[c] = num_p[c];
        assign q_prev[c]   = '0;
      end
    end else begin : g_rest
      assign r_prev = div_r[j-1];
      for (genvar c = 0; c < 3; c++) begin : g_c
        assign rem_prev[c] = div_rem[j-1][c];
        assign q_prev[c]   = div_q[j-1][c];
      end
    end
    assign dv = (NUM_W+1)'(r_prev) << K;
    always_comb begin
      for (int c = 0; c < 3; c++) begin
        rx[c] = {1'b0, rem_prev[c]};
        rd[c] = rx[c] - dv;
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        div_r[j] <= r_prev;
        for (int c = 0; c < 3; c++) begin
          if (rx[c] >= dv) begin
            div_rem[j][c] <= rd[c][NUM_W-1:0];
            div_q[j][c]   <= q_prev[c] | (ROOT_W'(1) << K);
          end else begin
            div_rem[j][c] <= rem_prev[c];
            div_q[j][c]   <= q_prev[c];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        vec_out[c] <= sgn[NST-2][c] ? -{1'b0, div_q[NSTEP-1][c]} : {1'b0, div_q[NSTEP-1][c]};
      end
    end
  end

  assign v_out    = v[NST-1];
  assign side_out = side[NST-1];

endmodule

[design/three_point_local_frame.sv]
// Top level of the three-point local frame pipeline with its configuration registers.
//
//   channel  kind       direction  contents
//   points   valid/ready  in       origin, axis point and plane point, Q16.16
//   frame    valid/ready  out      3x3 rotation matrix in Q1.30 and degenerate flag
//   apb      psel/penable in/out   use_default_plane at 0x0, parallel_limit at 0x4
//
// One request is accepted per cycle while the result is not held; the pipeline depth lies
// mostly in the two normalizer chains (31 root steps and 31 divide steps each). Reset
// clears every stage valid bit and loads the register defaults. When the result is held,
// every stage holds and no request is taken.
`timescale 1ns / 1ps
module three_point_local_frame (
  input  logic                          clk,
  input  logic                          rst,
  tplf_point_if.sink                    points,
  tplf_frame_if.source                  frame,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tplf_pkg::ADDR_W-1:0]   paddr,
  input  logic [tplf_pkg::DATA_W-1:0]   pwdata,
  output logic [tplf_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);

  localparam int DW = tplf_pkg::DIFF_W;
  localparam int PW = tplf_pkg::PRE_W;
  localparam int OW = tplf_pkg::OUT_W;
  localparam int XW = tplf_pkg::PROD_W;
  localparam int LW = tplf_pkg::LIMIT_W;

  logic          use_default_plane;
  logic [LW-1:0] parallel_limit;
  logic          en;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      use_default_plane <= 1'b0;
      parallel_limit    <= tplf_pkg::LIMIT_RST;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        tplf_pkg::REG_USE_DEFAULT: use_default_plane <= pwdata[0];
        tplf_pkg::REG_LIMIT:       parallel_limit    <= pwdata[LW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      tplf_pkg::REG_USE_DEFAULT: prdata = {{(tplf_pkg::DATA_W-1){1'b0}}, use_default_plane};
      tplf_pkg::REG_LIMIT:       prdata = {{(tplf_pkg::DATA_W-LW){1'b0}}, parallel_limit};
      default:                   prdata = '0;
    endcase
  end

  logic o_v;
  assign en           = !o_v || frame.ready;
  assign points.ready = en;

  // Point differences.
  logic                 s1_v;
  logic signed [DW-1:0] s1_a [3];
  logic signed [DW-1:0] s1_d [3];

  always_ff @(posedge clk) begin
    if (rst) s1_v <= 1'b0;
    else if (en) s1_v <= points.valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_a[0] <= DW'(points.axis_pt_x) - DW'(points.origin_x);
      s1_a[1] <= DW'(points.axis_pt_y) - DW'(points.origin_y);
      s1_a[2] <= DW'(points.axis_pt_z) - DW'(points.origin_z);
      s1_d[0] <= DW'(points.plane_pt_x) - DW'(points.origin_x);
      s1_d[1] <= DW'(points.plane_pt_y) - DW'(points.origin_y);
      s1_d[2] <= DW'(points.plane_pt_z) - DW'(points.origin_z);
    end
  end

  logic                 pa_v, pd_v;
  logic signed [PW-1:0] pa_vec [3];
  logic signed [PW-1:0] pd_vec [3];
  logic                 pa_side;
  logic [LW-1:0]        pd_side;

  tplf_prescale #(.W(DW), .SW(1)) u_pre_a (
    .clk(clk), .rst(rst), .en(en), .v_in(s1_v), .vec_in(s1_a),
    .side_in(use_default_plane), .v_out(pa_v), .vec_out(pa_vec), .side_out(pa_side)
  );

  tplf_prescale #(.W(DW), .SW(LW)) u_pre_d (
    .clk(clk), .rst(rst), .en(en), .v_in(s1_v), .vec_in(s1_d),
    .side_in(parallel_limit), .v_out(pd_v), .vec_out(pd_vec), .side_out(pd_side)
  );

  localparam int NA_SW = 1 + 3 * PW + 1 + LW;

  logic                 a_zero;
  logic [NA_SW-1:0]     na_side_in, na_side;
  logic                 na_v;
  logic signed [OW-1:0] na_vec [3];

  assign a_zero     = (pa_vec[0] == '0) && (pa_vec[1] == '0) && (pa_vec[2] == '0);
  assign na_side_in = {a_zero, pd_vec[0], pd_vec[1], pd_vec[2], pa_side, pd_side};

  tplf_norm #(.SW(NA_SW)) u_norm_a (
    .clk(clk), .rst(rst), .en(en), .v_in(pa_v), .vec_in(pa_vec),
    .side_in(na_side_in), .v_out(na_v), .vec_out(na_vec), .side_out(na_side)
  );

  // Helper direction selection.
  logic                 na_dg, na_udp;
  logic [LW-1:0]        na_lim;
  logic signed [PW-1:0] na_d [3];
  logic signed [OW-1:0] ay_neg;
  logic [OW-1:0]        ay_mag;
  logic                 ay_over;

  assign na_dg   = na_side[NA_SW-1];
  assign na_d[0] = na_side[NA_SW-2 -: PW];
  assign na_d[1] = na_side[NA_SW-2-PW -: PW];
  assign na_d[2] = na_side[NA_SW-2-2*PW -: PW];
  assign na_udp  = na_side[LW];
  assign na_lim  = na_side[LW-1:0];
  assign ay_neg  = -na_vec[1];
  assign ay_mag  = na_vec[1][OW-1] ? ay_neg : na_vec[1];
  assign ay_over = ay_mag > {{(OW-LW){1'b0}}, na_lim};

  logic                 t2_v, t2_dg;
  logic signed [OW-1:0] t2_a [3];
  logic signed [OW-1:0] t2_d [3];

  always_ff @(posedge clk) begin
    if (rst) t2_v <= 1'b0;
    else if (en) t2_v <= na_v;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t2_dg <= na_dg;
      for (int c = 0; c < 3; c++) t2_a[c] <= na_vec[c];
      if (na_udp) begin
        t2_d[0] <= ay_over ? tplf_pkg::ONE_Q30 : '0;
        t2_d[1] <= ay_over ? '0 : tplf_pkg::ONE_Q30;
        t2_d[2] <= '0;
      end else begin
        for (int c = 0; c < 3; c++) t2_d[c] <= OW'(na_d[c]);
      end
    end
  end

  // c = a x d
  logic                 t3_v, t3_dg;
  logic signed [OW-1:0] t3_a [3];
  logic signed [XW-1:0] t3_pp [3];
  logic signed [XW-1:0] t3_pm [3];

  always_ff @(posedge clk) begin
    if (rst) t3_v <= 1'b0;
    else if (en) t3_v <= t2_v;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t3_dg    <= t2_dg;
      t3_a     <= t2_a;
      t3_pp[0] <= t2_a[1] * t2_d[2];
      t3_pm[0] <= t2_a[2] * t2_d[1];
      t3_pp[1] <= t2_a[2] * t2_d[0];
      t3_pm[1] <= t2_a[0] * t2_d[2];
      t3_pp[2] <= t2_a[0] * t2_d[1];
      t3_pm[2] <= t2_a[1] * t2_d[0];
    end
  end

  logic                 t4_v, t4_dg;
  logic signed [OW-1:0] t4_a [3];
  logic signed [XW-1:0] t4_c [3];

  always_ff @(posedge clk) begin
    if (rst) t4_v <= 1'b0;
    else if (en) t4_v <= t3_v;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t4_dg <= t3_dg;
      t4_a  <= t3_a;
      for (int c = 0; c < 3; c++) t4_c[c] <= t3_pp[c] - t3_pm[c];
    end
  end

  localparam int PC_SW = 1 + 3 * OW;

  logic                 pc_v;
  logic signed [PW-1:0] pc_vec [3];
  logic [PC_SW-1:0]     pc_side;

  tplf_prescale #(.W(XW), .SW(PC_SW)) u_pre_c (
    .clk(clk), .rst(rst), .en(en), .v_in(t4_v), .vec_in(t4_c),
    .side_in({t4_dg, t4_a[0], t4_a[1], t4_a[2]}),
    .v_out(pc_v), .vec_out(pc_vec), .side_out(pc_side)
  );

  // b = c x a
  logic                 c_zero;
  logic signed [OW-1:0] pc_a [3];

  assign c_zero  = (pc_vec[0] == '0) && (pc_vec[1] == '0) && (pc_vec[2] == '0);
  assign pc_a[0] = pc_side[3*OW-1 -: OW];
  assign pc_a[1] = pc_side[2*OW-1 -: OW];
  assign pc_a[2] = pc_side[OW-1:0];

  logic                 t5_v, t5_dg;
  logic signed [OW-1:0] t5_a [3];
  logic signed [PW-1:0] t5_c [3];
  logic signed [XW-1:0] t5_pp [3];
  logic signed [XW-1:0] t5_pm [3];

  always_ff @(posedge clk) begin
    if (rst) t5_v <= 1'b0;
    else if (en) t5_v <= pc_v;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t5_dg    <= pc_side[PC_SW-1] || c_zero;
      t5_a     <= pc_a;
      t5_c     <= pc_vec;
      t5_pp[0] <= pc_vec[1] * pc_a[2];
      t5_pm[0] <= pc_vec[2] * pc_a[1];
      t5_pp[1] <= pc_vec[2] * pc_a[0];
      t5_pm[1] <= pc_vec[0] * pc_a[2];
      t5_pp[2] <= pc_vec[0] * pc_a[1];
      t5_pm[2] <= pc_vec[1] * pc_a[0];
    end
  end

  logic                 t6_v, t6_dg;
  logic signed [OW-1:0] t6_a [3];
  logic signed [PW-1:0] t6_c [3];
  logic signed [XW-1:0] t6_b [3];

  always_ff @(posedge clk) begin
    if (rst) t6_v <= 1'b0;
    else if (en) t6_v <= t5_v;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t6_dg <= t5_dg;
      t6_a  <= t5_a;
      t6_c  <= t5_c;
      for (int c = 0; c < 3; c++) t6_b[c] <= t5_pp[c] - t5_pm[c];
    end
  end

  localparam int PB_SW = 1 + 3 * OW + 3 * PW;

  logic                 pb_v;
  logic signed [PW-1:0] pb_vec [3];
  logic [PB_SW-1:0]     pb_side;

  tplf_prescale #(.W(XW), .SW(PB_SW)) u_pre_b (
    .clk(clk), .rst(rst), .en(en), .v_in(t6_v), .vec_in(t6_b),
    .side_in({t6_dg, t6_a[0], t6_a[1], t6_a[2], t6_c[0], t6_c[1], t6_c[2]}),
    .v_out(pb_v), .vec_out(pb_vec), .side_out(pb_side)
  );

  logic                 b_zero, pb_dg;
  logic signed [PW-1:0] pb_c [3];

  assign b_zero  = (pb_vec[0] == '0) && (pb_vec[1] == '0) && (pb_vec[2] == '0);
  assign pb_dg   = pb_side[PB_SW-1] || b_zero;
  assign pb_c[0] = pb_side[3*PW-1 -: PW];
  assign pb_c[1] = pb_side[2*PW-1 -: PW];
  assign pb_c[2] = pb_side[PW-1:0];

  logic                 nb_v, nc_v, nc_side;
  logic signed [OW-1:0] nb_vec [3];
  logic signed [OW-1:0] nc_vec [3];
  logic [3*OW-1:0]      nb_side;

  tplf_norm #(.SW(3 * OW)) u_norm_b (
    .clk(clk), .rst(rst), .en(en), .v_in(pb_v), .vec_in(pb_vec),
    .side_in(pb_side[PB_SW-2 -: 3*OW]), .v_out(nb_v), .vec_out(nb_vec), .side_out(nb_side)
  );

  tplf_norm #(.SW(1)) u_norm_c (
    .clk(clk), .rst(rst), .en(en), .v_in(pb_v), .vec_in(pb_c),
    .side_in(pb_dg), .v_out(nc_v), .vec_out(nc_vec), .side_out(nc_side)
  );

  always_ff @(posedge clk) begin
    if (rst) o_v <= 1'b0;
    else if (en) o_v <= nb_v;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      frame.m00        <= nb_side[3*OW-1 -: OW];
      frame.m10        <= nb_side[2*OW-1 -: OW];
      frame.m20        <= nb_side[OW-1:0];
      frame.m01        <= nb_vec[0];
      frame.m11        <= nb_vec[1];
      frame.m21        <= nb_vec[2];
      frame.m02        <= nc_vec[0];
      frame.m12        <= nc_vec[1];
      frame.m22        <= nc_vec[2];
      frame.degenerate <= nc_side;
    end
  end

  assign frame.valid = o_v;

  a_pre_lockstep: assert property (@(posedge clk) disable iff (rst) pa_v == pd_v)
    else $error("Prescalers for a and d are out of step.");

  a_norm_lockstep: assert property (@(posedge clk) disable iff (rst) nb_v == nc_v)
    else $error("Normalizers for b and c are out of step.");

  a_zero_axis_flag: assert property (@(posedge clk) disable iff (rst)
    (frame.valid && frame.m00 == '0 && frame.m10 == '0 && frame.m20 == '0)
      |-> frame.degenerate)
    else $error("Zero first axis without the degenerate flag.");

  a_third_axis_live: assert property (@(posedge clk) disable iff (rst)
    (frame.valid && !frame.degenerate)
      |-> !(frame.m02 == '0 && frame.m12 == '0 && frame.m22 == '0))
    else $error("Zero third axis on a frame that is not flagged degenerate.");

endmodule

[tb/tb_three_point_local_frame.sv]
// Self-checking testbench for the three-point local frame pipeline.
`timescale 1ns / 1ps
module tb_three_point_local_frame;

  localparam int LIMIT_CYCLES = 2000000;
  localparam int DRAIN_CYCLES = 160;
  localparam longint Q30 = 64'sd1 << 30;

  typedef struct {
    logic signed [31:0] o[3];
    logic signed [31:0] ax[3];
    logic signed [31:0] pl[3];
  } points_t;

  typedef struct {
    logic signed [31:0] m[9];
    logic degenerate;
  } frame_t;

  class frame_scoreboard;
    bit use_default;
    logic [tplf_pkg::LIMIT_W-1:0] limit;
    frame_t expected_q[$];
    int mismatches;

    function new();
      use_default = 1'b0;
      limit = tplf_pkg::LIMIT_RST;
      mismatches = 0;
    endfunction

    function longint unsigned mag(longint x);
      return x < 0 ? longint'(-x) : x;
    endfunction

    function bit prescale(inout longint v[3]);
      longint unsigned m[3];
      longint unsigned mx;
      mx = 0;
      for (int i = 0; i < 3; i++) begin
        m[i] = mag(v[i]);
        if (m[i] > mx) mx = m[i];
      end
      if (mx == 0) return 1'b0;
      while (mx >= (64'd1 << 30)) begin
        for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
        mx = mx >> 1;
      end
      while (mx < (64'd1 << 29)) begin
        for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
        mx = mx << 1;
      end
      for (int i = 0; i < 3; i++) v[i] = v[i] < 0 ? -longint'(m[i]) : longint'(m[i]);
      return 1'b1;
    endfunction

    function longint unsigned int_root(longint unsigned s);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > s) b = b >> 2;
      while (b != 0) begin
        if (s >= res + b) begin
          s = s - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return res;
    endfunction

    function bit to_unit(inout longint v[3]);
      longint unsigned s, r, m, q;
      if (!prescale(v)) begin
        for (int i = 0; i < 3; i++) v[i] = 0;
        return 1'b0;
      end
      s = 0;
      for (int i = 0; i < 3; i++) s = s + mag(v[i]) * mag(v[i]);
      r = int_root(s);
      if (r == 0) r = 1;
      for (int i = 0; i < 3; i++) begin
        m = mag(v[i]);
        q = ((m << 30) + (r >> 1)) / r;
        v[i] = v[i] < 0 ? -longint'(q) : longint'(q);
      end
      return 1'b1;
    endfunction

    function void cross3(longint p[3], longint q[3], output longint r[3]);
      r[0] = p[1] * q[2] - p[2] * q[1];
      r[1] = p[2] * q[0] - p[0] * q[2];
      r[2] = p[0] * q[1] - p[1] * q[0];
    endfunction

    function void note_points(points_t p);
      longint a[3], d[3], c[3], b[3], cn[3];
      frame_t f;
      bit degen;
      degen = 1'b0;
      for (int i = 0; i < 3; i++) begin
        a[i] = longint'(p.ax[i]) - longint'(p.o[i]);
        d[i] = longint'(p.pl[i]) - longint'(p.o[i]);
      end
      if (!to_unit(a)) degen = 1'b1;
      if (use_default) begin
        d[0] = 0;
        d[1] = Q30;
        d[2] = 0;
        if (mag(a[1]) > longint'(limit)) begin
          d[0] = Q30;
          d[1] = 0;
        end
      end else begin
        void'(prescale(d));
      end
      cross3(a, d, c);
      if (!prescale(c)) degen = 1'b1;
      cross3(c, a, b);
      cn = c;
      void'(to_unit(cn));
      if (!to_unit(b)) degen = 1'b1;
      for (int i = 0; i < 3; i++) begin
        f.m[i*3+0] = a[i][31:0];
        f.m[i*3+1] = b[i][31:0];
        f.m[i*3+2] = cn[i][31:0];
      end
      f.degenerate = degen;
      expected_q.push_back(f);
    endfunction

    function void check_frame(frame_t got);
      frame_t exp_f;
      bit bad;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected frame result m00=%0d", got.m[0]);
        return;
      end
      exp_f = expected_q.pop_front();
      bad = (got.degenerate !== exp_f.degenerate);
      for (int i = 0; i < 9; i++) if (got.m[i] !== exp_f.m[i]) bad = 1'b1;
      if (bad) begin
        mismatches++;
        if (mismatches <= 10) begin
          for (int i = 0; i < 9; i++)
            $display("m%0d%0d expected %0d got %0d", i / 3, i % 3, exp_f.m[i], got.m[i]);
          $display("degenerate expected %0b got %0b", exp_f.degenerate, got.degenerate);
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic psel, penable, pwrite;
  logic [tplf_pkg::ADDR_W-1:0] paddr;
  logic [tplf_pkg::DATA_W-1:0] pwdata;
  logic [tplf_pkg::DATA_W-1:0] prdata;
  logic pready;

  tplf_point_if pts_if ();
  tplf_frame_if frm_if ();

  three_point_local_frame u_top (
    .clk(clk), .rst(rst), .points(pts_if.sink), .frame(frm_if.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  frame_scoreboard sb;
  bit idle_en;
  int hold_left;
  int stall_left;
  int cycles;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("tb_three_point_local_frame: FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    points_t p;
    frame_t f;
    if (!rst && pts_if.valid && pts_if.ready) begin
      p.o  = '{pts_if.origin_x, pts_if.origin_y, pts_if.origin_z};
      p.ax = '{pts_if.axis_pt_x, pts_if.axis_pt_y, pts_if.axis_pt_z};
      p.pl = '{pts_if.plane_pt_x, pts_if.plane_pt_y, pts_if.plane_pt_z};
      sb.note_points(p);
    end
    if (!rst && frm_if.valid && frm_if.ready) begin
      f.m = '{frm_if.m00, frm_if.m01, frm_if.m02, frm_if.m10, frm_if.m11,
              frm_if.m12, frm_if.m20, frm_if.m21, frm_if.m22};
      f.degenerate = frm_if.degenerate;
      sb.check_frame(f);
    end
  end

  always @(negedge clk) begin
    if (hold_left > 0) begin
      frm_if.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (stall_left > 0) begin
      frm_if.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_en && $urandom_range(0, 11) == 0) begin
      frm_if.ready <= 1'b0;
      stall_left <= $urandom_range(0, 17);
    end else begin
      frm_if.ready <= 1'b1;
    end
  end

  task automatic reg_write(input logic idx, input logic [tplf_pkg::DATA_W-1:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == tplf_pkg::REG_USE_DEFAULT) sb.use_default = value[0];
    else sb.limit = value[tplf_pkg::LIMIT_W-1:0];
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic send_points(input points_t p);
    if (idle_en && $urandom_range(0, 5) == 0) begin
      pts_if.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    pts_if.valid <= 1'b1;
    pts_if.origin_x <= p.o[0];
    pts_if.origin_y <= p.o[1];
    pts_if.origin_z <= p.o[2];
    pts_if.axis_pt_x <= p.ax[0];
    pts_if.axis_pt_y <= p.ax[1];
    pts_if.axis_pt_z <= p.ax[2];
    pts_if.plane_pt_x <= p.pl[0];
    pts_if.plane_pt_y <= p.pl[1];
    pts_if.plane_pt_z <= p.pl[2];
    do @(posedge clk); while (!pts_if.ready);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    pts_if.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic logic signed [31:0] srand(int bits);
    return $signed($urandom) >>> (31 - bits);
  endfunction

  function automatic points_t random_points();
    points_t p;
    int k;
    for (int i = 0; i < 3; i++) begin
      p.o[i] = srand(20);
      p.ax[i] = p.o[i] + srand(18);
      p.pl[i] = p.o[i] + srand(18);
    end
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        for (int i = 0; i < 3; i++) begin
          p.o[i] = $urandom;
          p.ax[i] = $urandom;
          p.pl[i] = $urandom;
        end
      end
      3: p.ax = p.o;
      4: begin
        k = $urandom_range(0, 6) - 3;
        for (int i = 0; i < 3; i++) p.pl[i] = p.o[i] + k * (p.ax[i] - p.o[i]);
      end
      5: begin
        p.ax[0] = p.o[0] + srand(12);
        p.ax[1] = p.o[1] + srand(18);
        p.ax[2] = p.o[2] + srand(12);
      end
      6: p.pl = p.o;
      default: ;
    endcase
    return p;
  endfunction

  function automatic points_t make_points(logic signed [31:0] v[9]);
    points_t p;
    for (int i = 0; i < 3; i++) begin
      p.o[i] = v[i];
      p.ax[i] = v[3+i];
      p.pl[i] = v[6+i];
    end
    return p;
  endfunction

  task automatic run_random(int count);
    repeat (count) send_points(random_points());
  endtask

  localparam logic signed [31:0] MX = 32'sh7fff_ffff;
  localparam logic signed [31:0] MN = 32'sh8000_0000;
  localparam logic signed [31:0] U1 = 32'sh0001_0000;

  initial begin
    sb = new();
    cycles = 0;
    idle_en = 1'b1;
    hold_left = 0;
    stall_left = 0;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    pts_if.valid = 1'b0;
    {pts_if.origin_x, pts_if.origin_y, pts_if.origin_z} = '0;
    {pts_if.axis_pt_x, pts_if.axis_pt_y, pts_if.axis_pt_z} = '0;
    {pts_if.plane_pt_x, pts_if.plane_pt_y, pts_if.plane_pt_z} = '0;
    frm_if.ready = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_points(make_points('{0, 0, 0, U1, 0, 0, 0, U1, 0}));
    send_points(make_points('{MN, MN, MN, MX, MX, MX, MN, MX, MN}));
    send_points(make_points('{MX, MX, MX, MN, MN, MN, MX, MN, MX}));
    send_points(make_points('{MN, 0, MX, MX, 0, MN, 0, MX, 0}));
    send_points(make_points('{5, 5, 5, 5, 5, 5, 7, 8, 9}));
    send_points(make_points('{MX, MN, 0, MX, MN, 0, MX, MN, 0}));
    send_points(make_points('{0, 0, 0, U1, U1, 0, 2 * U1, 2 * U1, 0}));
    send_points(make_points('{1, 2, 3, 4, 5, 6, 1, 2, 3}));
    send_points(make_points('{0, 0, 0, 1, 0, 0, 0, 0, 1}));
    send_points(make_points('{0, 0, 0, -1, -1, -1, 1, -1, 0}));
    send_points(make_points('{0, 0, 0, 0, U1, 0, U1, 0, 0}));
    send_points(make_points('{-1, -1, -1, 0, 0, 0, -1, 0, 0}));
    send_points(make_points('{0, MN, 0, 0, MX, 0, MX, 0, MN}));
    send_points(make_points('{0, 0, 0, 3, -7, 11, -13, 17, -19}));
    run_random(60);
    wait_drained();

    reg_write(tplf_pkg::REG_USE_DEFAULT, 32'd1);
    reg_write(tplf_pkg::REG_LIMIT, tplf_pkg::LIMIT_RST);
    send_points(make_points('{0, 0, 0, 0, U1, 0, 0, 0, 0}));
    send_points(make_points('{0, 0, 0, 0, -U1, 0, 1, 2, 3}));
    send_points(make_points('{0, 0, 0, 1000, U1, 0, 0, 0, 0}));
    send_points(make_points('{0, 0, 0, 0, 0, 0, 0, 0, 0}));
    @(posedge clk);
    hold_left = 400;
    run_random(80);
    wait_drained();

    reg_write(tplf_pkg::REG_LIMIT, 32'd0);
    run_random(60);
    wait_drained();

    reg_write(tplf_pkg::REG_LIMIT, 32'h4000_0000);
    send_points(make_points('{0, 0, 0, 0, U1, 0, 0, 0, 0}));
    run_random(60);
    wait_drained();

    reg_write(tplf_pkg::REG_USE_DEFAULT, 32'd0);
    reg_write(tplf_pkg::REG_LIMIT, 32'h7fff_ffff);
    idle_en = 1'b0;
    run_random(120);
    wait_drained();

    if (sb.mismatches == 0) begin
      $display("tb_three_point_local_frame: PASS");
    end else begin
      $display("tb_three_point_local_frame: FAIL");
    end
    $finish;
  end

endmodule
